// ----- rtl/core/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg
// Shared constants and controller/datapath interface types for the rational
// arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int RAU_OPERAND_WIDTH = 16;

    // Operation codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // Multiplier product selects
    localparam logic [1:0] MSEL_P0 = 2'd0;  // first numerator term
    localparam logic [1:0] MSEL_P1 = 2'd1;  // cross term
    localparam logic [1:0] MSEL_P2 = 2'd2;  // denominator

    // Divider dividend selects
    localparam logic DSEL_NUM = 1'b0;
    localparam logic DSEL_DEN = 1'b1;

    typedef struct packed {
        logic       load;      // capture operands
        logic       mul_en;    // register one product
        logic [1:0] mul_sel;
        logic       sum_en;    // form raw numerator and denominator
        logic       gcd_init;  // load magnitudes into the GCD unit
        logic       gcd_step;  // one binary GCD step
        logic       div_load;  // load a dividend into the divider
        logic       div_sel;
        logic       div_step;  // one restoring division step
        logic       q_save;    // hold numerator quotient
        logic       out_en;    // update result registers
        logic       out_raw;   // pass raw parts unchanged
    } rau_cmd_t;

    typedef struct packed {
        logic zero_part;  // raw numerator or denominator is zero
        logic gcd_equal;  // GCD unit has converged
    } rau_stat_t;

endpackage

// ----- rtl/core/rau_ctrl.sv -----
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencing state machine: products, sum, binary GCD, two divisions, output.
// ----------------------------------------------------------------------------
module rau_ctrl #(
    parameter int OPERAND_WIDTH = rau_pkg::RAU_OPERAND_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    output rau_pkg::rau_cmd_t   cmd,
    input  rau_pkg::rau_stat_t  stat
);
    import rau_pkg::*;

    localparam int NUMW = (2 * OPERAND_WIDTH + 1 > 64) ? 64 : 2 * OPERAND_WIDTH + 1;
    localparam int CW   = $clog2(NUMW);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_MUL0    = 4'd1;
    localparam logic [3:0] S_MUL1    = 4'd2;
    localparam logic [3:0] S_MUL2    = 4'd3;
    localparam logic [3:0] S_SUM     = 4'd4;
    localparam logic [3:0] S_GINIT   = 4'd5;
    localparam logic [3:0] S_GCD     = 4'd6;
    localparam logic [3:0] S_DIVN_LD = 4'd7;
    localparam logic [3:0] S_DIVN    = 4'd8;
    localparam logic [3:0] S_DIVD_LD = 4'd9;
    localparam logic [3:0] S_DIVD    = 4'd10;
    localparam logic [3:0] S_OUT     = 4'd11;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          raw_reg, raw_next;
    logic          done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        raw_next   = raw_reg;
        done_next  = 1'b0;
        cmd        = '0;
        cmd.out_raw = raw_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL0;
                end
            end
            S_MUL0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_P0;
                state_next  = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_P1;
                state_next  = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_P2;
                state_next  = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = S_GINIT;
            end
            S_GINIT:
            begin
                raw_next = stat.zero_part;
                if (stat.zero_part)
                    state_next = S_OUT;
                else
                begin
                    cmd.gcd_init = 1'b1;
                    state_next   = S_GCD;
                end
            end
            S_GCD:
            begin
                // the datapath captures the divisor on the converged step
                cmd.gcd_step = 1'b1;
                if (stat.gcd_equal)
                    state_next = S_DIVN_LD;
            end
            S_DIVN_LD:
            begin
                cmd.div_load = 1'b1;
                cmd.div_sel  = DSEL_NUM;
                cnt_next     = CW'(NUMW - 1);
                state_next   = S_DIVN;
            end
            S_DIVN:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = S_DIVD_LD;
            end
            S_DIVD_LD:
            begin
                cmd.q_save   = 1'b1;
                cmd.div_load = 1'b1;
                cmd.div_sel  = DSEL_DEN;
                cnt_next     = CW'(NUMW - 1);
                state_next   = S_DIVD;
            end
            S_DIVD:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.out_en = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            raw_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            raw_reg   <= raw_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

// ----- rtl/core/rau_dp.sv -----
// ----------------------------------------------------------------------------
// rau_dp
// Datapath: shared multiplier, raw sum, binary GCD unit, restoring divider
// and result registers.
// ----------------------------------------------------------------------------
module rau_dp #(
    parameter int OPERAND_WIDTH = rau_pkg::RAU_OPERAND_WIDTH
) (
    input  logic                                clk,
    input  rau_pkg::rau_cmd_t                   cmd,
    output rau_pkg::rau_stat_t                  stat,
    input  logic [1:0]                          operation,
    input  logic signed [OPERAND_WIDTH-1:0]     a_num,
    input  logic signed [OPERAND_WIDTH-1:0]     a_den,
    input  logic signed [OPERAND_WIDTH-1:0]     b_num,
    input  logic signed [OPERAND_WIDTH-1:0]     b_den,
    output logic signed [2*OPERAND_WIDTH:0]     res_num,
    output logic signed [2*OPERAND_WIDTH-1:0]   res_den
);
    import rau_pkg::*;

    localparam int W    = OPERAND_WIDTH;
    localparam int PW   = 2 * W;
    localparam int RNW  = 2 * W + 1;
    localparam int DENW = 2 * W;
    localparam int NUMW = (2 * W + 1 > 64) ? 64 : 2 * W + 1;
    localparam int KW   = $clog2(NUMW + 1);

    logic [1:0]              op_reg;
    logic signed [W-1:0]     an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [PW-1:0]    p0_reg, p1_reg, p2_reg;
    logic signed [NUMW-1:0]  num_reg;
    logic signed [DENW-1:0]  den_reg;
    logic [NUMW-1:0]         u_reg, v_reg, g_reg;
    logic [KW-1:0]           k_reg;
    logic [NUMW-1:0]         dvd_reg, rem_reg, qn_reg;
    logic signed [RNW-1:0]   res_num_reg;
    logic signed [DENW-1:0]  res_den_reg;

    // Shared multiplier
    logic signed [W-1:0]  mul_a, mul_b;
    logic signed [PW-1:0] prod;

    always_comb
    begin
        mul_a = an_reg;
        mul_b = bd_reg;
        case (cmd.mul_sel)
            MSEL_P0:
            begin
                mul_a = an_reg;
                mul_b = (op_reg == OP_MUL) ? bn_reg : bd_reg;
            end
            MSEL_P1:
            begin
                mul_a = bn_reg;
                mul_b = ad_reg;
            end
            default:
            begin
                mul_a = ad_reg;
                mul_b = (op_reg == OP_DIV) ? bn_reg : bd_reg;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Raw parts
    logic signed [NUMW-1:0] num_sum;

    always_comb
    begin
        case (op_reg)
            OP_ADD:  num_sum = NUMW'(p0_reg) + NUMW'(p1_reg);
            OP_SUB:  num_sum = NUMW'(p0_reg) - NUMW'(p1_reg);
            default: num_sum = NUMW'(p0_reg);
        endcase
    end

    logic            num_neg, den_neg;
    logic [NUMW-1:0] num_mag;
    logic [DENW-1:0] den_mag;

    assign num_neg = num_reg[NUMW-1];
    assign den_neg = den_reg[DENW-1];
    assign num_mag = num_neg ? NUMW'(-num_reg) : NUMW'(num_reg);
    assign den_mag = den_neg ? DENW'(-den_reg) : DENW'(den_reg);

    assign stat.zero_part = (num_reg == '0) || (den_reg == '0);
    assign stat.gcd_equal = (u_reg == v_reg);

    // Binary GCD step
    logic            u_ge;
    logic [NUMW-1:0] gdiff;

    assign u_ge  = (u_reg >= v_reg);
    assign gdiff = u_ge ? (u_reg - v_reg) : (v_reg - u_reg);

    // Restoring divider step
    logic [NUMW:0]   trial;
    logic            qbit;
    logic [NUMW-1:0] rem_step;

    assign trial    = {rem_reg, dvd_reg[NUMW-1]};
    assign qbit     = (trial >= {1'b0, g_reg});
    assign rem_step = qbit ? NUMW'(trial - {1'b0, g_reg}) : trial[NUMW-1:0];

    // Signed quotients
    logic [NUMW-1:0]        qn_signed, qd_signed;

    assign qn_signed = num_neg ? (~qn_reg + 1'b1) : qn_reg;
    assign qd_signed = den_neg ? (~dvd_reg + 1'b1) : dvd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= operation;
            an_reg <= a_num;
            ad_reg <= a_den;
            bn_reg <= b_num;
            bd_reg <= b_den;
        end

        if (cmd.mul_en)
        begin
            case (cmd.mul_sel)
                MSEL_P0: p0_reg <= prod;
                MSEL_P1: p1_reg <= prod;
                default: p2_reg <= prod;
            endcase
        end

        if (cmd.sum_en)
        begin
            num_reg <= num_sum;
            den_reg <= p2_reg;
        end

        if (cmd.gcd_init)
        begin
            u_reg <= num_mag;
            v_reg <= NUMW'(den_mag);
            k_reg <= '0;
        end
        else if (cmd.gcd_step)
        begin
            if (u_reg == v_reg)
                g_reg <= u_reg << k_reg;
            else if (!u_reg[0] && !v_reg[0])
            begin
                u_reg <= u_reg >> 1;
                v_reg <= v_reg >> 1;
                k_reg <= k_reg + 1'b1;
            end
            else if (!u_reg[0])
                u_reg <= u_reg >> 1;
            else if (!v_reg[0])
                v_reg <= v_reg >> 1;
            else if (u_ge)
                u_reg <= gdiff >> 1;
            else
                v_reg <= gdiff >> 1;
        end

        if (cmd.q_save)
            qn_reg <= dvd_reg;

        if (cmd.div_load)
        begin
            dvd_reg <= (cmd.div_sel == DSEL_NUM) ? num_mag : NUMW'(den_mag);
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[NUMW-2:0], qbit};
            rem_reg <= rem_step;
        end

        if (cmd.out_en)
        begin
            // at the widest setting the 64-bit parts are zero-extended
            if (cmd.out_raw)
            begin
                res_num_reg <= RNW'($unsigned(num_reg));
                res_den_reg <= den_reg;
            end
            else
            begin
                res_num_reg <= RNW'(qn_signed);
                res_den_reg <= qd_signed[DENW-1:0];
            end
        end
    end

    assign res_num = res_num_reg;
    assign res_den = res_den_reg;

endmodule

// ----- rtl/core/rational_arith_unit.sv -----
// ----------------------------------------------------------------------------
// rational_arith_unit
// Exact add, subtract, multiply or divide of two signed fractions, with the
// result reduced by the GCD of its magnitudes.
// ----------------------------------------------------------------------------
// A transaction is taken on a clock edge where start is high and busy is low;
// busy then stays high until the result is out. The unit works on one
// transaction at a time. Cost is set by the binary GCD loop, which runs one
// step per cycle and takes fewer steps for small values, and by the
// one-bit-per-cycle restoring divider, which runs once for the numerator and
// once for the denominator. When the raw numerator or denominator is zero the
// GCD and division are skipped and the raw parts come out unchanged,
// including a zero denominator. Signs are not normalized: each part keeps its
// own sign. The result on res_num/res_den is flagged by done high for exactly
// one cycle; the receiver cannot stall it, so capture it then.
// res_num is 2*OPERAND_WIDTH+1 bits and res_den 2*OPERAND_WIDTH bits.
// ----------------------------------------------------------------------------
module rational_arith_unit #(
    parameter int OPERAND_WIDTH = rau_pkg::RAU_OPERAND_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          operation,
    input  logic signed [OPERAND_WIDTH-1:0]     a_num,
    input  logic signed [OPERAND_WIDTH-1:0]     a_den,
    input  logic signed [OPERAND_WIDTH-1:0]     b_num,
    input  logic signed [OPERAND_WIDTH-1:0]     b_den,
    output logic                                done,
    output logic signed [2*OPERAND_WIDTH:0]     res_num,
    output logic signed [2*OPERAND_WIDTH-1:0]   res_den
);
    import rau_pkg::*;

    rau_cmd_t  cmd;
    rau_stat_t stat;

    // Controller: sequences the datapath and owns the handshake
    rau_ctrl #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    // Datapath: operands are captured on the accepting edge
    rau_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .clk       (clk),
        .cmd       (cmd),
        .stat      (stat),
        .operation (operation),
        .a_num     (a_num),
        .a_den     (a_den),
        .b_num     (b_num),
        .b_den     (b_den),
        .res_num   (res_num),
        .res_den   (res_den)
    );

endmodule

// ----- rtl/core/rau_checker.sv -----
// ----------------------------------------------------------------------------
// rau_checker
// Port-level timing checks for the rational arithmetic unit.
// ----------------------------------------------------------------------------
module rau_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // An accepted transaction makes the unit busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // A result only comes out once the unit has gone idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // busy drops only together with the result strobe
    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (busy || done))
        else $error("busy dropped without a result");

    // One result per transaction: the strobe lasts a single cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule

bind rational_arith_unit rau_checker u_rau_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
